// ----- hdl/cbmt_pkg.sv -----
// Shared types, constants and helpers for the cartridge bank mapper and play timer.
`default_nettype none

package cbmt_pkg;

  // Depth of the byte RAM in the low half of the bus window (a power of two, 256 to 2048).
  localparam int WINDOW_DEPTH = 2048;
  localparam int RAM_AW       = $clog2(WINDOW_DEPTH);

  localparam logic [31:0] TIMER_BASE  = 32'h2000_0000;
  localparam logic [7:0]  STATUS_BYTE = 8'h5C;
  localparam logic [7:0]  EXPIRED_BIT = 8'h80;

  typedef logic [RAM_AW-1:0] ram_idx_t;

  typedef enum logic [2:0] {
    KIND_TICK  = 3'd0,
    KIND_READ  = 3'd1,
    KIND_WRITE = 3'd2,
    KIND_PRG   = 3'd3,
    KIND_CHR   = 3'd4
  } kind_t;

  // Request from the decoder to the timer for one accepted item.
  typedef struct packed {
    logic       fire;
    logic       enable;
    logic [9:0] cycles;
  } timer_req_t;

  // Access to the window RAM for one accepted item.
  typedef struct packed {
    logic     rd;
    logic     wr;
    ram_idx_t idx;
    logic [7:0] wdata;
  } ram_req_t;

  function automatic ram_idx_t ram_index(input logic [11:0] address);
    logic [10:0] offs;
    offs = address[10:0];
    return RAM_AW'(offs % WINDOW_DEPTH);
  endfunction

endpackage

`default_nettype wire

// ----- hdl/cartridge_bank_mapper_timer.sv -----
// Top level of the cartridge bank mapper with play timer.
// Usage. Items arrive on the in_ stream: in_tuser carries the kind (tick, bus
// read, bus write, PRG request, CHR request) and in_tdata the address, data byte
// and tick cycle count. Every accepted item yields exactly one result transfer on
// the out_ stream with the read byte, the final bank, the CHR-RAM select and the
// timer expired flag as it stands after that item.
//
// A result appears on out_ the cycle after its input transfer. The block takes one item
// per clock while the receiver does not stall; the window RAM is single ported and
// each item makes at most one access to it, so it sets no lower rate. The timer
// add and target compare complete in the cycle of the input transfer.
//
// When the receiver stalls, the result register holds its value and the RAM read
// register holds its byte; in_tready drops only while a result is waiting and
// out_tready is low, so the next item can be accepted in the same cycle in which
// the waiting result is taken.
//
// Users write the dip setting via cfg_we/cfg_wdata while the block is idle (unenforced).
// Reset (rst_n low, synchronous) clears the registers, counter and flag and empties the
// result stage; the window RAM is not cleared and must be written before it is read.
`default_nettype none

module cartridge_bank_mapper_timer
  import cbmt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input stream.
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // address[11:0], data[19:12], tick_cycles[29:20], 0
  input  wire logic [2:0]  in_tuser,   // kind[2:0]
  // Result stream.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // read_data[7:0], bank[15:8], chr_ram_select[16],
                                       // timer_expired[17], 0
  // Configuration.
  input  wire logic        cfg_we,
  input  wire logic [3:0]  cfg_wdata
);

  logic [11:0] in_address;
  logic [7:0]  in_data;
  logic [9:0]  in_cycles;
  logic        in_xfer;

  logic [3:0]  dip_r;
  logic [7:0]  mode_r, mode_nxt;

  timer_req_t  tmr_req;
  ram_req_t    ram_req;
  logic        flag_now, flag_nxt;
  logic [7:0]  ram_q;

  // Result stage.
  logic        res_valid_r, res_valid_nxt;
  logic        res_ram_r;
  logic [7:0]  res_rd_r, res_bank_r;
  logic        res_sel_r, res_exp_r;
  logic        res_ram_nxt;
  logic [7:0]  res_rd_nxt, res_bank_nxt;
  logic        res_sel_nxt;
  logic [7:0]  read_byte;
  logic [7:0]  chr_base;

  assign in_address = in_tdata[11:0];
  assign in_data    = in_tdata[19:12];
  assign in_cycles  = in_tdata[29:20];

  // The result stage frees up in the same cycle in which its result is taken.
  assign in_tready = !res_valid_r || out_tready;
  assign in_xfer   = in_tvalid && in_tready;

  assign chr_base = {mode_r[2], 7'd0};

  // Decode of the accepted item: register writes, RAM access, timer request and
  // the bank mapping. Only the RAM byte itself comes through the registered RAM read.
  always_comb begin
    mode_nxt       = mode_r;
    tmr_req        = '0;
    tmr_req.enable = mode_r[3];
    tmr_req.cycles = in_cycles;
    ram_req        = '0;
    ram_req.idx    = ram_index(in_address);
    ram_req.wdata  = in_data;
    res_ram_nxt    = 1'b0;
    res_rd_nxt     = '0;
    res_bank_nxt   = '0;
    res_sel_nxt    = 1'b0;
    if (in_xfer) begin
      case (kind_t'(in_tuser))
        KIND_TICK: begin
          tmr_req.fire = 1'b1;
        end
        KIND_READ: begin
          if (in_address[11]) begin
            res_rd_nxt = STATUS_BYTE | (flag_now ? EXPIRED_BIT : 8'h00);
          end else begin
            ram_req.rd  = 1'b1;
            res_ram_nxt = 1'b1;
          end
        end
        KIND_WRITE: begin
          // The upper outer register has no effect on any result, so a write
          // to it is taken and dropped.
          if (in_address[11]) begin
            if (!in_address[10]) begin
              mode_nxt = in_data;
            end
          end else begin
            ram_req.wr = 1'b1;
          end
        end
        KIND_PRG: begin
          res_bank_nxt = {2'b00, mode_r[2], 5'd0}
                       | (in_data & {3'b000, mode_r[1:0], 3'b111});
        end
        KIND_CHR: begin
          if (mode_r[2:1] == 2'b01) begin
            if (in_data[6]) begin
              res_sel_nxt  = 1'b1;
              res_bank_nxt = {5'd0, in_data[2:0]};
            end else begin
              res_bank_nxt = chr_base | in_data;
            end
          end else begin
            res_bank_nxt = chr_base | {1'b0, in_data[6:0]};
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    res_valid_nxt = res_valid_r;
    if (in_xfer) begin
      res_valid_nxt = 1'b1;
    end else if (out_tready) begin
      res_valid_nxt = 1'b0;
    end
  end

  cbmt_timer u_timer (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (tmr_req),
    .dip      (dip_r),
    .flag     (flag_now),
    .flag_nxt (flag_nxt)
  );

  cbmt_window_ram u_ram (
    .clk (clk),
    .req (ram_req),
    .q   (ram_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dip_r       <= '0;
      mode_r      <= '0;
      res_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        dip_r <= cfg_wdata;
      end
      mode_r      <= mode_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      res_ram_r  <= res_ram_nxt;
      res_rd_r   <= res_rd_nxt;
      res_bank_r <= res_bank_nxt;
      res_sel_r  <= res_sel_nxt;
      res_exp_r  <= flag_nxt;
    end
  end

  assign read_byte  = res_ram_r ? ram_q : res_rd_r;
  assign out_tvalid = res_valid_r;
  assign out_tdata  = {6'd0, res_exp_r, res_sel_r, res_bank_r, read_byte};

endmodule

`default_nettype wire

// ----- hdl/cbmt_window_ram.sv -----
// Single-port byte RAM for the low half of the bus window, registered read data.
`default_nettype none

module cbmt_window_ram
  import cbmt_pkg::*;
(
  input  wire logic       clk,
  input  wire ram_req_t   req,
  output logic [7:0]      q
);

  logic [7:0] mem [WINDOW_DEPTH];
  logic [7:0] q_r;

  // The read register holds its value while no read is issued, so a stalled
  // result keeps its byte.
  always_ff @(posedge clk) begin
    if (req.wr) begin
      mem[req.idx] <= req.wdata;
    end
    if (req.rd) begin
      q_r <= mem[req.idx];
    end
  end

  assign q = q_r;

endmodule

`default_nettype wire

// ----- hdl/cbmt_timer.sv -----
// Play timer: 32-bit cycle counter and the expired flag.
`default_nettype none

module cbmt_timer
  import cbmt_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire timer_req_t req,
  input  wire logic [3:0] dip,
  output logic            flag,
  output logic            flag_nxt
);

  logic [31:0] count_r, count_nxt;
  logic        flag_r;
  logic [31:0] target;
  logic [31:0] gap;
  logic [31:0] step;

  assign target = TIMER_BASE | {3'b000, dip, 25'd0};
  assign gap    = target - count_r;
  assign step   = {22'd0, req.cycles};

  always_comb begin
    count_nxt = count_r;
    flag_nxt  = flag_r;
    if (req.fire && (req.cycles != 10'd0)) begin
      if (!req.enable) begin
        count_nxt = '0;
        flag_nxt  = 1'b0;
      end else begin
        // The flag rises only when the count steps onto or across the target.
        if ((gap != 32'd0) && (gap <= step)) begin
          flag_nxt = 1'b1;
        end
        count_nxt = count_r + step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      flag_r  <= 1'b0;
    end else begin
      count_r <= count_nxt;
      flag_r  <= flag_nxt;
    end
  end

  assign flag = flag_r;

endmodule

`default_nettype wire

// ----- hdl/cbmt_checker.sv -----
// Port-level checker for the cartridge bank mapper and play timer, with its bind.
`default_nettype none

module cbmt_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [23:0] out_tdata
);

  // A waiting result holds until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Reset leaves the result stage empty.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // Every input transfer yields a result in the next cycle.
  a_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("no result after input transfer");

  // An empty result stage never blocks the input.
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty result stage");

  // A CHR-RAM bank lies within the eight RAM banks.
  a_chr_ram_bank: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[16] |-> out_tdata[15:11] == 5'd0)
    else $error("CHR-RAM bank out of range");

endmodule

bind cartridge_bank_mapper_timer cbmt_checker u_cbmt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

// ----- sim/tb_cartridge_bank_mapper_timer.sv -----
// Self-checking testbench for the cartridge bank mapper with play timer.
//
// Bus, tick and bank-request items are queued by one initial block, driven onto the in_
// stream by a clocked driver and predicted by a clocked monitor. The monitor checks each
// out_ transfer field by field against the oldest prediction.
//
// The run covers these parts in order, the last two each followed by a random phase:
// - a short directed part;
// - random phases under different idling of the sender and the receiver;
// - a long receiver hold-off;
// - a short timer part that runs the counter with the enable bit set, then checks that a
//   zero-length tick keeps the state and a real tick with the bit clear clears it.
import cbmt_pkg::*;

module tb_cartridge_bank_mapper_timer;

  // The unused kinds sit above the last named kind.
  localparam logic [2:0]  KIND_UNUSED_FIRST = 3'd5;
  localparam logic [2:0]  KIND_UNUSED_LAST  = 3'd7;
  localparam logic [11:0] MODE_ADDR         = 12'h800;
  localparam logic [11:0] SPARE_ADDR        = 12'hC00;
  localparam int          HOLD_CYCLES       = 250;
  localparam int          QUEUE_HIGH        = 16;
  localparam int unsigned CYCLE_LIMIT       = 4_000_000;

  typedef struct packed {
    logic [2:0]  kind;
    logic [11:0] address;
    logic [7:0]  data;
    logic [9:0]  cycles;
  } cart_req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [7:0] bank;
    logic       chr_ram_sel;
    logic       expired;
  } cart_reply_t;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata    = '0;   // address[11:0], data[19:12], tick_cycles[29:20], 0
  logic [2:0]  in_tuser    = '0;   // kind[2:0]
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [23:0] out_tdata;          // read_data[7:0], bank[15:8], chr_ram_select[16],
                                   // timer_expired[17], 0
  logic        cfg_we      = 1'b0;
  logic [3:0]  cfg_wdata   = '0;

  cartridge_bank_mapper_timer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  always #6 clk = ~clk;

  // Items waiting to be driven, and replies predicted but not yet seen.
  cart_req_t   cart_requests[$];
  cart_reply_t predicted_replies[$];

  // Idling of the two sides in percent; the generator changes them between phases.
  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;
  logic        hold_active = 1'b0;
  event        hold_trigger;

  int unsigned mismatches      = 0;
  int unsigned items_accepted  = 0;
  int unsigned replies_checked = 0;
  int unsigned expired_replies = 0;
  int unsigned cycle_count     = 0;

  // Predictor copy of the block's state and registers, with the spare register it drops.
  logic [3:0]  dip_q     = '0;
  logic [7:0]  mode_q    = '0;
  logic [7:0]  spare_q   = '0;
  logic [31:0] counter_q = '0;
  logic        expired_q = 1'b0;
  logic [7:0]  ram_q [WINDOW_DEPTH];

  // Generator bookkeeping: which RAM bytes have already been written, so that reads only
  // ever land on written bytes.
  bit ram_loaded [WINDOW_DEPTH];
  int loaded_idx[$];

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH at cycle %0d: %s got 0x%0h, predicted 0x%0h",
             cycle_count, what, got, want);
    mismatches++;
  endtask

  // Works out the reply to one accepted item and advances the predictor state.
  function automatic cart_reply_t predict_reply(input cart_req_t r);
    cart_reply_t rep;
    logic [31:0] target;
    logic [31:0] gap;
    int          idx;
    rep = '0;
    idx = int'(r.address[10:0]) % WINDOW_DEPTH;
    case (r.kind)
      KIND_TICK: begin
        // A zero-length tick leaves everything alone, even with the enable bit clear.
        if (r.cycles != 0) begin
          if (!mode_q[3]) begin
            counter_q = '0;
            expired_q = 1'b0;
          end else begin
            target = TIMER_BASE | (32'(dip_q) << 25);
            gap    = target - counter_q;
            // The flag rises only when this tick steps onto or across the target.
            if (gap >= 1 && gap <= 32'(r.cycles)) expired_q = 1'b1;
            counter_q = counter_q + 32'(r.cycles);
          end
        end
      end
      KIND_READ: begin
        if (r.address[11]) rep.read_data = STATUS_BYTE | (expired_q ? EXPIRED_BIT : 8'h00);
        else rep.read_data = ram_q[idx];
      end
      KIND_WRITE: begin
        if (r.address[11]) begin
          if (r.address[10]) spare_q = r.data;
          else mode_q = r.data;
        end else begin
          ram_q[idx] = r.data;
        end
      end
      KIND_PRG: begin
        // Mode bits 1:0 open bank bits 4:3, and mode bit 2 becomes bank bit 5.
        rep.bank = {2'b00, mode_q[2], r.data[4:0] & {mode_q[1:0], 3'b111}};
      end
      KIND_CHR: begin
        if (mode_q[2:1] == 2'b01) begin
          if (r.data[6]) begin
            rep.chr_ram_sel = 1'b1;
            rep.bank        = {5'b0, r.data[2:0]};
          end else begin
            rep.bank = {mode_q[2] | r.data[7], r.data[6:0]};
          end
        end else begin
          rep.bank = {mode_q[2], r.data[6:0]};
        end
      end
      default: begin
        // Unused kinds change nothing and report only the flag.
      end
    endcase
    rep.expired = expired_q;
    return rep;
  endfunction

  task automatic check_reply(input logic [23:0] tdata);
    cart_reply_t want;
    if (predicted_replies.size() == 0) begin
      $display("MISMATCH at cycle %0d: result 0x%0h with no prediction waiting",
               cycle_count, tdata);
      mismatches++;
    end else begin
      want = predicted_replies.pop_front();
      if (tdata[7:0] !== want.read_data) report_mismatch("read_data", tdata[7:0], want.read_data);
      if (tdata[15:8] !== want.bank) report_mismatch("bank", tdata[15:8], want.bank);
      if (tdata[16] !== want.chr_ram_sel)
        report_mismatch("chr_ram_select", tdata[16], want.chr_ram_sel);
      if (tdata[17] !== want.expired) report_mismatch("timer_expired", tdata[17], want.expired);
      replies_checked++;
    end
  endtask

  // Driver: a new item is presented only when the previous one has been transferred or
  // none was being offered, so in_tvalid never drops while an item is waiting.
  cart_req_t drive_req;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (cart_requests.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
        drive_req = cart_requests.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= {2'b00, drive_req.cycles, drive_req.data, drive_req.address};
        in_tuser  <= drive_req.kind;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, overridden by the long hold-off.
  always @(posedge clk) begin
    out_tready <= hold_active ? 1'b0 : ($urandom_range(0, 99) >= stall_pct);
  end

  // The long hold-off counts its own cycles so that the generator can keep feeding items.
  initial begin
    @(hold_trigger);
    hold_active <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_active <= 1'b0;
  end

  // Monitor: values sampled here are those from before this edge's updates.
  cart_req_t   seen_req;
  cart_reply_t seen_reply;
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) dip_q = cfg_wdata;
      if (in_tvalid && in_tready) begin
        seen_req   = '{kind: in_tuser, address: in_tdata[11:0], data: in_tdata[19:12],
                       cycles: in_tdata[29:20]};
        seen_reply = predict_reply(seen_req);
        predicted_replies.push_back(seen_reply);
        items_accepted++;
        if (seen_reply.expired) expired_replies++;
      end
      if (out_tvalid && out_tready) check_reply(out_tdata);
    end
  end

  // Timeout watchdog.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timed out after %0d cycles with %0d results outstanding",
             cycle_count, predicted_replies.size());
    $display("end of test: mismatches");
    $finish;
  end

  task automatic send(input logic [2:0] k, input logic [11:0] a, input logic [7:0] d,
                      input logic [9:0] c);
    cart_req_t r;
    int        idx;
    r = '{kind: k, address: a, data: d, cycles: c};
    if (k == KIND_WRITE && !a[11]) begin
      idx = int'(a[10:0]) % WINDOW_DEPTH;
      if (!ram_loaded[idx]) begin
        ram_loaded[idx] = 1'b1;
        loaded_idx.push_back(idx);
      end
    end
    while (cart_requests.size() >= QUEUE_HIGH) @(negedge clk);
    cart_requests.push_back(r);
  endtask

  // Waits until every item has been transferred and every reply has come back, then lets
  // the pipeline settle.
  task automatic wait_drained();
    do @(negedge clk);
    while (cart_requests.size() != 0 || in_tvalid || predicted_replies.size() != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_dip(input logic [3:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic send_random();
    int          pick;
    int          sub;
    logic [11:0] a;
    logic [7:0]  d;
    logic [9:0]  c;
    pick = $urandom_range(0, 99);
    sub  = $urandom_range(0, 99);
    a    = 12'($urandom_range(0, 4095));
    d    = 8'($urandom_range(0, 255));
    c    = 10'($urandom_range(0, 1023));
    if (pick < 18) begin
      if (sub < 10) c = '0;
      send(KIND_TICK, a, d, c);
    end else if (pick < 36) begin
      // Low-half reads only go to bytes already written; the rest hit the status byte.
      if (loaded_idx.size() != 0 && sub < 60)
        a = {1'b0, 11'(loaded_idx[$urandom_range(0, loaded_idx.size() - 1)])};
      else
        a[11] = 1'b1;
      send(KIND_READ, a, d, c);
    end else if (pick < 58) begin
      if (sub < 30) a = MODE_ADDR | {2'b00, a[9:0]};
      else if (sub < 40) a = SPARE_ADDR | {2'b00, a[9:0]};
      else a[11] = 1'b0;
      send(KIND_WRITE, a, d, c);
    end else if (pick < 75) begin
      send(KIND_PRG, a, d, c);
    end else if (pick < 94) begin
      send(KIND_CHR, a, d, c);
    end else begin
      send(3'($urandom_range(KIND_UNUSED_FIRST, KIND_UNUSED_LAST)), a, d, c);
    end
  endtask

  task automatic random_phase(input int count, input int unsigned idle,
                              input int unsigned stall);
    idle_pct  = idle;
    stall_pct = stall;
    repeat (count) send_random();
    wait_drained();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: the top dip value, all kinds and the field extremes.
    write_dip(4'hF);
    send(KIND_TICK, 12'hFFF, 8'hFF, 10'd0);       // zero-length tick
    send(KIND_TICK, 12'h000, 8'h00, 10'd1023);    // enable clear: counter held at zero
    send(KIND_WRITE, 12'h000, 8'h00, 10'd0);
    send(KIND_WRITE, 12'h7FF, 8'hFF, 10'd1023);
    send(KIND_WRITE, 12'h5A5, 8'hA5, 10'd0);
    send(KIND_READ, 12'h000, 8'hFF, 10'd1023);
    send(KIND_READ, 12'h7FF, 8'h00, 10'd0);
    send(KIND_READ, 12'h5A5, 8'h00, 10'd0);
    send(KIND_READ, 12'h800, 8'h00, 10'd0);       // status byte
    send(KIND_READ, 12'hFFF, 8'hFF, 10'd1023);
    send(KIND_WRITE, 12'hFFF, 8'hFF, 10'd0);      // spare register
    send(KIND_WRITE, MODE_ADDR, 8'hFF, 10'd0);
    send(KIND_PRG, 12'h000, 8'hFF, 10'd0);
    send(KIND_PRG, 12'hFFF, 8'h00, 10'd0);
    send(KIND_CHR, 12'h000, 8'hFF, 10'd0);
    send(KIND_TICK, 12'h000, 8'h00, 10'd1023);    // enable set: counter runs
    send(KIND_WRITE, 12'hBFF, 8'h02, 10'd0);      // CHR RAM mode
    send(KIND_CHR, 12'h000, 8'h40, 10'd0);
    send(KIND_CHR, 12'h000, 8'hBF, 10'd0);
    send(KIND_CHR, 12'h000, 8'hC7, 10'd0);
    send(KIND_PRG, 12'h000, 8'hFF, 10'd0);
    send(KIND_UNUSED_FIRST, 12'hFFF, 8'hFF, 10'd1023);
    send(3'd6, 12'h000, 8'h00, 10'd0);
    send(KIND_UNUSED_LAST, 12'hFFF, 8'hFF, 10'd1023);
    wait_drained();

    // Random phases under each idling pattern, with the dip setting moved between them.
    write_dip(4'h0);
    random_phase(300, 0, 0);
    write_dip(4'h7);
    random_phase(300, 75, 0);
    write_dip(4'hF);
    random_phase(300, 0, 75);

    // Receiver holds off while the sender keeps offering, so the input side backs up.
    idle_pct  = 0;
    stall_pct = 0;
    -> hold_trigger;
    repeat (40) send_random();
    wait_drained();
    write_dip(4'h8);
    random_phase(300, 22, 22);

    // Timer part: clear the counter, let it run with the enable bit set, then clear it.
    idle_pct  = 0;
    stall_pct = 0;
    send(KIND_WRITE, MODE_ADDR, 8'h00, 10'd0);
    send(KIND_TICK, '0, '0, 10'd5);
    send(KIND_WRITE, MODE_ADDR, 8'h08, 10'd0);
    repeat (8) send(KIND_TICK, '0, '0, 10'd1023);
    send(KIND_READ, MODE_ADDR, '0, '0);
    send(KIND_WRITE, MODE_ADDR, 8'h00, 10'd0);
    send(KIND_TICK, '0, '0, 10'd0);               // zero-length tick keeps the state
    send(KIND_READ, MODE_ADDR, '0, '0);
    send(KIND_TICK, '0, '0, 10'd1);               // enable clear: flag and counter cleared
    send(KIND_READ, MODE_ADDR, '0, '0);
    wait_drained();

    write_dip(4'h0);
    random_phase(100, 22, 22);

    repeat (4) @(posedge clk);
    if (predicted_replies.size() != 0) begin
      $display("MISMATCH: %0d predicted results never arrived", predicted_replies.size());
      mismatches++;
    end
    $display("Run covered %0d items and %0d checked results over %0d cycles,",
             items_accepted, replies_checked, cycle_count);
    $display("including %0d results with the timer expired and %0d mismatches.",
             expired_replies, mismatches);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
